[rtl/mao_pkg.sv]
// Shared types and constants for the moving average outlier filter.
package mao_pkg;

   // Field widths fixed by the item and register formats.
   localparam int SAMPLE_W   = 12;
   localparam int STATUS_W   = 2;
   localparam int WLEN_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int CMP_W      = SAMPLE_W + 2;
   localparam int DCNT_W     = $clog2(SAMPLE_W);

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEP   = CSR_IDX_W'(1);

   // Register reset values and limits.
   localparam logic [WLEN_W-1:0]   WLEN_RESET     = WLEN_W'(10);
   localparam logic [WLEN_W-1:0]   WLEN_MIN       = WLEN_W'(2);
   localparam logic [SAMPLE_W-1:0] MAX_STEP_RESET = SAMPLE_W'(500);

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      RS_PRIMED   = 2'd0,
      RS_AVERAGED = 2'd1,
      RS_REJECTED = 2'd2
   } rsp_status_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_SUM,
      S_DIV,
      S_OUT
   } fsm_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_sample;
      logic evaluate;
      logic sum_step;
      logic div_step;
      logic emit;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic primed;
      logic take_ok;
      logic sum_done;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

endpackage

[rtl/mao_if.sv]
// Channel interfaces for the request, response and register write ports.

interface mao_req_if;
   logic                          valid;
   logic                          ready;
   logic [mao_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface mao_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mao_pkg::SAMPLE_W-1:0]  filtered;
   mao_pkg::rsp_status_type       status;

   modport source (output valid, output filtered, output status, input ready);
   modport sink   (input valid, input filtered, input status, output ready);
endinterface

interface mao_csr_if;
   logic                            valid;
   logic                            ready;
   logic [mao_pkg::CSR_IDX_W-1:0]   index;
   logic [mao_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/mao_ctrl.sv]
// Controller state machine sequencing evaluate, sum, divide and output.
module mao_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mao_pkg::dp_status_type status,
   output mao_pkg::ctl_cmd_type   cmd
);

   mao_pkg::fsm_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mao_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mao_pkg::S_IDLE: begin
            if (req_valid) state_in = mao_pkg::S_EVAL;
         end
         mao_pkg::S_EVAL: begin
            if (status.primed && status.take_ok) state_in = mao_pkg::S_SUM;
            else state_in = mao_pkg::S_OUT;
         end
         mao_pkg::S_SUM: begin
            if (status.sum_done) state_in = mao_pkg::S_DIV;
         end
         mao_pkg::S_DIV: begin
            if (status.div_done) state_in = mao_pkg::S_OUT;
         end
         mao_pkg::S_OUT: begin
            if (status.rsp_free) state_in = mao_pkg::S_IDLE;
         end
         default: state_in = mao_pkg::S_IDLE;
      endcase
   end

   // Outputs. No item is taken while reset is high.
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         mao_pkg::S_IDLE: begin
            req_ready       = !reset;
            cmd.take_sample = req_valid && !reset;
         end
         mao_pkg::S_EVAL: cmd.evaluate = 1'b1;
         mao_pkg::S_SUM:  cmd.sum_step = 1'b1;
         mao_pkg::S_DIV:  cmd.div_step = 1'b1;
         mao_pkg::S_OUT:  cmd.emit     = status.rsp_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[rtl/mao_dp.sv]
// Datapath: registers, sample window, acceptance check, summer and divider.
module mao_dp #(
   parameter int WINDOW_MAX = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mao_pkg::ctl_cmd_type   cmd,
   output mao_pkg::dp_status_type status,
   input  logic [mao_pkg::SAMPLE_W-1:0] req_sample,
   mao_rsp_if.source              rsp,
   mao_csr_if.sink                csr
);

   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = mao_pkg::SAMPLE_W + IDX_W;

   logic [mao_pkg::WLEN_W-1:0]     wlen_ff;
   logic [mao_pkg::SAMPLE_W-1:0]   step_ff;
   logic [mao_pkg::SAMPLE_W-1:0]   sample_ff;
   logic [mao_pkg::SAMPLE_W-1:0]   window_ff [WINDOW_MAX];
   logic                           primed_ff;
   logic [mao_pkg::SAMPLE_W-1:0]   held_ff;
   mao_pkg::rsp_status_type        stat_ff;
   logic [IDX_W-1:0]               cnt_ff;
   logic [SUM_W-1:0]               acc_ff;
   logic [LEN_W-1:0]               rem_ff;
   logic [mao_pkg::SAMPLE_W-1:0]   quo_ff;
   logic [mao_pkg::DCNT_W-1:0]     dcnt_ff;
   logic                           rsp_valid_ff;
   logic [mao_pkg::SAMPLE_W-1:0]   rsp_filt_ff;
   mao_pkg::rsp_status_type        rsp_stat_ff;

   logic [LEN_W-1:0]               eff_len;
   logic [IDX_W-1:0]               last_idx;
   logic [IDX_W-1:0]               rd_idx;
   logic [mao_pkg::SAMPLE_W-1:0]   rd_data;
   logic signed [mao_pkg::CMP_W-1:0] raw_s, last_s, step_s, lo_s, hi_s;
   logic                           take_ok;
   logic [SUM_W-1:0]               sum_in;
   logic [LEN_W:0]                 trial;
   logic                           qbit;
   logic [LEN_W-1:0]               rem_in;
   logic [mao_pkg::SAMPLE_W-1:0]   quo_in;
   logic                           sum_last;
   logic                           div_last;
   logic                           rsp_free;

   // Configuration registers; writes are taken whenever reset is low.
   assign csr.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= mao_pkg::WLEN_RESET;
         step_ff <= mao_pkg::MAX_STEP_RESET;
      end else if (csr.valid) begin
         if (csr.index == mao_pkg::CSR_WINDOW_LEN) wlen_ff <= csr.data[mao_pkg::WLEN_W-1:0];
         if (csr.index == mao_pkg::CSR_MAX_STEP)   step_ff <= csr.data;
      end
   end

   // Effective window length, clamped to the supported range.
   always_comb begin
      if (wlen_ff < mao_pkg::WLEN_MIN) begin
         eff_len = LEN_W'(mao_pkg::WLEN_MIN);
      end else if (32'(wlen_ff) > WINDOW_MAX) begin
         eff_len = LEN_W'(WINDOW_MAX);
      end else begin
         eff_len = LEN_W'(wlen_ff);
      end
   end

   assign last_idx = IDX_W'(eff_len - LEN_W'(1));

   // Single window read port: newest entry while evaluating, else the sum index.
   assign rd_idx  = cmd.evaluate ? last_idx : cnt_ff;
   assign rd_data = window_ff[rd_idx];

   // Acceptance window around the newest stored entry, signed compare.
   always_comb begin
      raw_s   = $signed({2'b00, sample_ff});
      last_s  = $signed({2'b00, rd_data});
      step_s  = $signed({2'b00, step_ff});
      lo_s    = last_s - step_s;
      hi_s    = last_s + step_s;
      take_ok = ((raw_s >= step_s) && (raw_s > lo_s) && (raw_s < hi_s)) ||
                ((raw_s <= step_s) && (raw_s > 0) && (raw_s < hi_s));
   end

   // Accumulator and one restoring divide step.
   always_comb begin
      sum_in = acc_ff + SUM_W'(rd_data);
      trial  = {rem_ff, quo_ff[mao_pkg::SAMPLE_W-1]};
      qbit   = (trial >= {1'b0, eff_len});
      rem_in = qbit ? LEN_W'(trial - {1'b0, eff_len}) : LEN_W'(trial);
      quo_in = {quo_ff[mao_pkg::SAMPLE_W-2:0], qbit};
   end

   assign sum_last = (cnt_ff == last_idx);
   assign div_last = (dcnt_ff == mao_pkg::DCNT_W'(mao_pkg::SAMPLE_W - 1));
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   assign status.primed   = primed_ff;
   assign status.take_ok  = take_ok;
   assign status.sum_done = sum_last;
   assign status.div_done = div_last;
   assign status.rsp_free = rsp_free;

   // Sample capture.
   always_ff @(posedge clock) begin
      if (cmd.take_sample) sample_ff <= req_sample;
   end

   // Window storage: fill on priming, shift in on an accepted sample.
   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (cmd.evaluate) begin
            if (!primed_ff) begin
               if (IDX_W'(i) <= last_idx) window_ff[i] <= sample_ff;
            end else if (take_ok) begin
               if (IDX_W'(i) == last_idx) window_ff[i] <= sample_ff;
               else if (IDX_W'(i) < last_idx && i + 1 < WINDOW_MAX)
                  window_ff[i] <= window_ff[(i + 1) % WINDOW_MAX];
            end
         end
      end
   end

   // Primed flag and held output value.
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         held_ff   <= '0;
      end else begin
         if (cmd.evaluate) begin
            if (!primed_ff) begin
               primed_ff <= 1'b1;
               held_ff   <= sample_ff;
            end else if (!take_ok) begin
               primed_ff <= 1'b0;
            end
         end
         if (cmd.div_step && div_last) held_ff <= quo_in;
      end
   end

   // Item status, summing and dividing.
   always_ff @(posedge clock) begin
      if (cmd.evaluate) begin
         cnt_ff <= '0;
         acc_ff <= '0;
         if (!primed_ff)   stat_ff <= mao_pkg::RS_PRIMED;
         else if (take_ok) stat_ff <= mao_pkg::RS_AVERAGED;
         else              stat_ff <= mao_pkg::RS_REJECTED;
      end
      if (cmd.sum_step) begin
         acc_ff <= sum_in;
         cnt_ff <= cnt_ff + IDX_W'(1);
         if (sum_last) begin
            // The top bits of the sum are already below the divisor.
            rem_ff  <= LEN_W'(sum_in >> mao_pkg::SAMPLE_W);
            quo_ff  <= sum_in[mao_pkg::SAMPLE_W-1:0];
            dcnt_ff <= '0;
         end
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         dcnt_ff <= dcnt_ff + mao_pkg::DCNT_W'(1);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_filt_ff <= held_ff;
         rsp_stat_ff <= stat_ff;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.filtered = rsp_filt_ff;
   assign rsp.status   = rsp_stat_ff;

endmodule

[rtl/moving_average_outlier_filter.sv]
// Top level of the moving average filter with outlier rejection.
//
//   Channel   Direction  Payload                       Handshake
//   req_bus   in         sample[11:0]                  valid / ready
//   rsp_bus   out        filtered[11:0], status[1:0]   valid / ready
//   csr_bus   in         index[1:0], data[11:0]        valid / ready (ready high out of reset)
//
// A priming or rejected item passes from the evaluate state to the output register;
// an averaged item passes through one evaluate step, one step per window entry through
// the single accumulator, then 12 restoring divide steps, before the output register.
// Reset is synchronous, clears the primed flag, held value and handshake state, and no
// item or register write is taken while it is high.
// A new item is accepted while a result still waits; the block stalls only when it
// has finished the next result and the output register is still occupied.
module moving_average_outlier_filter #(
   parameter int WINDOW_MAX = 16
) (
   input logic        clock,
   input logic        reset,
   mao_req_if.sink    req_bus,
   mao_rsp_if.source  rsp_bus,
   mao_csr_if.sink    csr_bus
);

   mao_pkg::ctl_cmd_type   cmd;
   mao_pkg::dp_status_type status;

   mao_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mao_dp #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_sample (req_bus.sample),
      .rsp        (rsp_bus),
      .csr        (csr_bus)
   );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the moving average outlier filter.
module testbench;
   import mao_pkg::*;

   localparam int WINDOW_MAX   = 16;
   localparam int RANDOM_ITEMS = 1100;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [SAMPLE_W-1:0] filtered;
      rsp_status_type      status;
   } filter_result_type;

   typedef struct {
      bit                fixed;
      filter_result_type res;
   } typed_result_type;

   typedef enum bit {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [SAMPLE_W-1:0]   value;
      bit                    fixed;
      logic [SAMPLE_W-1:0]   filtered;
      rsp_status_type        status;
   } directed_row_type;

   localparam int NUM_ROWS = 27;

   // Directed rows: fixed results only where they follow directly from the rules.
   directed_row_type directed_rows [NUM_ROWS] = '{
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd0,    1'b1, 12'd0,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd0,    1'b1, 12'd0,    RS_REJECTED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd4095, 1'b1, 12'd4095, RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd4095, 1'b1, 12'd4095, RS_AVERAGED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd3596, 1'b0, 12'd0,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd3000, 1'b0, 12'd0,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd100,  1'b1, 12'd100,  RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd599,  1'b0, 12'd0,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd1100, 1'b0, 12'd0,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd1,    1'b1, 12'd1,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd500,  1'b0, 12'd0,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd1000, 1'b0, 12'd0,    RS_PRIMED},
      '{ROW_REG,  CSR_WINDOW_LEN, 12'hFFF,  1'b0, 12'd0,    RS_PRIMED},
      '{ROW_REG,  CSR_MAX_STEP,   12'd0,    1'b0, 12'd0,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd2048, 1'b1, 12'd2048, RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd2049, 1'b1, 12'd2048, RS_REJECTED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd2048, 1'b1, 12'd2048, RS_PRIMED},
      '{ROW_REG,  CSR_WINDOW_LEN, 12'hFE0,  1'b0, 12'd0,    RS_PRIMED},
      '{ROW_REG,  CSR_MAX_STEP,   12'd4095, 1'b0, 12'd0,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd4095, 1'b0, 12'd0,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd0,    1'b0, 12'd0,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd0,    1'b1, 12'd0,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd4095, 1'b1, 12'd0,    RS_REJECTED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd1,    1'b1, 12'd1,    RS_PRIMED},
      '{ROW_ITEM, CSR_WINDOW_LEN, 12'd4094, 1'b0, 12'd0,    RS_PRIMED},
      '{ROW_REG,  2'd2,           12'h5A5,  1'b0, 12'd0,    RS_PRIMED},
      '{ROW_REG,  2'd3,           12'hA5A,  1'b0, 12'd0,    RS_PRIMED}
   };

   logic clock;
   logic reset;

   mao_req_if req_if ();
   mao_rsp_if rsp_if ();
   mao_csr_if csr_if ();

   moving_average_outlier_filter #(
      .WINDOW_MAX(WINDOW_MAX)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // Predictor state, kept apart from the design.
   logic [SAMPLE_W-1:0] win_mem [WINDOW_MAX];
   bit                  is_primed   = 1'b0;
   logic [SAMPLE_W-1:0] held_level  = '0;
   int                  written_len = 0;
   logic [WLEN_W-1:0]   wlen_cfg    = WLEN_RESET;
   logic [SAMPLE_W-1:0] step_cfg    = MAX_STEP_RESET;

   filter_result_type due_results [$];
   typed_result_type  fixed_results [$];

   int items_sent   = 0;
   int results_seen = 0;
   int mismatches   = 0;

   // Clock and a single reset at the start.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Run limit.
   initial begin
      #10_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   function automatic int window_for(input logic [WLEN_W-1:0] len);
      if (len < WLEN_MIN) return 2;
      if (len > WINDOW_MAX) return WINDOW_MAX;
      return int'(len);
   endfunction

   // Works out the result of one accepted sample and updates the predictor state.
   function automatic filter_result_type predict_filter(input logic [SAMPLE_W-1:0] raw);
      filter_result_type res;
      int n, r, d, last, total, i;
      n = window_for(wlen_cfg);
      r = int'(raw);
      d = int'(step_cfg);
      if (!is_primed) begin
         for (i = 0; i < n; i++) win_mem[i] = raw;
         is_primed = 1'b1;
         held_level = raw;
         if (n > written_len) written_len = n;
         res.status = RS_PRIMED;
      end else begin
         last = int'(win_mem[n-1]);
         if ((r >= d && r > last - d && r < last + d) || (r <= d && r > 0 && r < last + d)) begin
            total = 0;
            for (i = 0; i + 1 < n; i++) win_mem[i] = win_mem[i+1];
            win_mem[n-1] = raw;
            for (i = 0; i < n; i++) total += int'(win_mem[i]);
            held_level = SAMPLE_W'(total / n);
            res.status = RS_AVERAGED;
         end else begin
            is_primed = 1'b0;
            res.status = RS_REJECTED;
         end
      end
      res.filtered = held_level;
      return res;
   endfunction

   // Gap length for either side: mostly none, some short, a few long.
   function automatic int pick_gap(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Scoreboard: predicts on every accepted item and checks every accepted result.
   always @(posedge clock) begin : scoreboard
      filter_result_type want;
      typed_result_type  typed;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_WINDOW_LEN: wlen_cfg = csr_if.data[WLEN_W-1:0];
               CSR_MAX_STEP:   step_cfg = csr_if.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            want = predict_filter(req_if.sample);
            if (fixed_results.size() > 0) begin
               typed = fixed_results.pop_front();
               if (typed.fixed) want = typed.res;
            end
            due_results.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: filtered %0d status %0d",
                           rsp_if.filtered, rsp_if.status);
            end else begin
               want = due_results.pop_front();
               if (rsp_if.filtered !== want.filtered || rsp_if.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("result %0d: filtered exp %0d got %0d, status exp %0d got %0d",
                              results_seen, want.filtered, rsp_if.filtered,
                              want.status, rsp_if.status);
               end
            end
         end
      end
   end

   // Receiver: random stalls, calm stretches and one long hold-off while items are offered.
   initial begin : rsp_ready_gen
      int gap;
      bit calm;
      bit long_hold_done;
      calm = 1'b0;
      long_hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 149) == 0) calm = !calm;
         if (!long_hold_done && results_seen >= 300 && req_if.valid) begin
            long_hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         gap = pick_gap(calm);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Offers one sample and returns at the edge where it was accepted, plus the gap.
   task automatic offer_sample(input logic [SAMPLE_W-1:0] value, input typed_result_type typed,
                               input int gap);
      fixed_results.push_back(typed);
      req_if.valid <= 1'b1;
      req_if.sample <= value;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every accepted item has its result.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (results_seen != items_sent) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Window length for a new phase; never lets the window reach entries not yet written.
   function automatic logic [CSR_DATA_W-1:0] pick_window_len();
      logic [CSR_DATA_W-1:0] data;
      int r;
      r = $urandom_range(0, 99);
      data = CSR_DATA_W'($urandom_range(0, 4095));
      if (r < 10)      data[WLEN_W-1:0] = WLEN_W'($urandom_range(0, 1));
      else if (r < 20) data[WLEN_W-1:0] = WLEN_W'($urandom_range(17, 31));
      else if (r < 30) data[WLEN_W-1:0] = WLEN_W'(WINDOW_MAX);
      else if (r < 40) data[WLEN_W-1:0] = WLEN_MIN;
      else             data[WLEN_W-1:0] = WLEN_W'($urandom_range(3, 15));
      if (is_primed && window_for(data[WLEN_W-1:0]) > written_len)
         data[WLEN_W-1:0] = WLEN_W'(written_len);
      return data;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_max_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)  return '0;
      if (r < 16) return '1;
      if (r < 26) return CSR_DATA_W'($urandom_range(1, 8));
      if (r < 36) return CSR_DATA_W'($urandom_range(2000, 4095));
      return CSR_DATA_W'($urandom_range(20, 800));
   endfunction

   // Next sample of a random walk: mostly within the allowed step, some outliers.
   function automatic logic [SAMPLE_W-1:0] next_sample(input int level);
      int r, d, span, s;
      d = int'(step_cfg);
      r = $urandom_range(0, 99);
      if (r < 75) begin
         span = (d == 0) ? 0 : d - 1;
         s = level + int'($urandom_range(0, 2 * span)) - span;
      end else if (r < 85) begin
         s = level + ($urandom_range(0, 1) ? d : -d) + int'($urandom_range(0, 2)) - 1;
      end else if (r < 90) begin
         s = 0;
      end else if (r < 93) begin
         s = 4095;
      end else begin
         s = $urandom_range(0, 4095);
      end
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      return SAMPLE_W'(s);
   endfunction

   // Stimulus: directed table, then phases of random walks under changing settings.
   initial begin : stimulus
      typed_result_type typed;
      logic [SAMPLE_W-1:0] value;
      int level, row, count, k;
      bit calm;
      req_if.valid = 1'b0;
      req_if.sample = '0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      level = 0;
      for (row = 0; row < NUM_ROWS; row++) begin
         if (directed_rows[row].kind == ROW_REG) begin
            drain_results();
            write_reg(directed_rows[row].index, directed_rows[row].value);
         end else begin
            typed.fixed = directed_rows[row].fixed;
            typed.res.filtered = directed_rows[row].filtered;
            typed.res.status = directed_rows[row].status;
            offer_sample(directed_rows[row].value, typed, pick_gap(1'b0));
            level = int'(directed_rows[row].value);
         end
      end

      typed.fixed = 1'b0;
      typed.res.filtered = '0;
      typed.res.status = RS_PRIMED;
      count = 0;
      while (count < RANDOM_ITEMS) begin
         // New settings only once the block has gone idle.
         drain_results();
         if ($urandom_range(0, 9) < 7) write_reg(CSR_WINDOW_LEN, pick_window_len());
         if ($urandom_range(0, 9) < 7) write_reg(CSR_MAX_STEP, pick_max_step());
         if ($urandom_range(0, 19) == 0)
            write_reg(CSR_IDX_W'($urandom_range(2, 3)), CSR_DATA_W'($urandom_range(0, 4095)));
         calm = ($urandom_range(0, 3) == 0);
         for (k = $urandom_range(20, 80); k > 0 && count < RANDOM_ITEMS; k--) begin
            value = next_sample(level);
            offer_sample(value, typed, pick_gap(calm));
            level = int'(value);
            count++;
         end
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

[sim.f]
rtl/mao_pkg.sv
rtl/mao_if.sv
rtl/mao_ctrl.sv
rtl/mao_dp.sv
rtl/moving_average_outlier_filter.sv
tb/testbench.sv
